// ===== src/wbps_pkg.sv =====
`timescale 1ns / 1ps

package wbps_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [2:0] CFG_PATTERN_LEN  = 3'd2;
    localparam logic [2:0] CFG_OFFSET       = 3'd3;
    localparam logic [2:0] CFG_START_ADDR   = 3'd4;
    localparam logic [2:0] CFG_END_ADDR     = 3'd5;

    localparam int          CFG_INDEX_W  = 3;
    localparam int          CFG_DATA_W   = 64;
    localparam int          ADDR_W       = 64;
    localparam int          LEN_W        = 5;
    localparam logic [7:0]  WILDCARD     = 8'hFF;

    // Live configuration seen by the scan logic
    typedef struct packed {
        logic [63:0]      pattern_low;
        logic [63:0]      pattern_high;
        logic [LEN_W-1:0] pattern_length;
        logic [31:0]      result_offset;
        logic [ADDR_W-1:0] start_address;
        logic [ADDR_W-1:0] end_address;
    } cfg_t;

    // One result request from the scan stage to the output register
    typedef struct packed {
        logic              push;
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } res_t;

endpackage

// ===== src/wbps_cfg.sv =====
`timescale 1ns / 1ps

module wbps_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output wbps_pkg::cfg_t                    cfg
);

    wbps_pkg::cfg_t cfg_reg;
    wbps_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                wbps_pkg::CFG_PATTERN_LOW:  cfg_next.pattern_low    = cfg_data;
                wbps_pkg::CFG_PATTERN_HIGH: cfg_next.pattern_high   = cfg_data;
                wbps_pkg::CFG_PATTERN_LEN:
                    cfg_next.pattern_length = cfg_data[wbps_pkg::LEN_W-1:0];
                wbps_pkg::CFG_OFFSET:       cfg_next.result_offset  = cfg_data[31:0];
                wbps_pkg::CFG_START_ADDR:   cfg_next.start_address  = cfg_data;
                wbps_pkg::CFG_END_ADDR:     cfg_next.end_address    = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.pattern_length <= wbps_pkg::LEN_W'(1);
            cfg_reg.result_offset  <= '0;
            cfg_reg.start_address  <= '0;
            cfg_reg.end_address    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/wbps_scan.sv =====
`timescale 1ns / 1ps

module wbps_scan
#(
    parameter int PATTERN_MAX = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  wbps_pkg::cfg_t cfg,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     data_byte,
    input  logic           first,
    input  logic           out_free,
    output wbps_pkg::res_t res
);

    localparam int SW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW = wbps_pkg::LEN_W;
    localparam int AW = wbps_pkg::ADDR_W;

    // Input register
    logic             in_vld_reg, in_vld_next;
    logic [7:0]       in_byte_reg;
    logic             in_first_reg;

    // Scan state
    logic [7:0]       win_reg  [PATTERN_MAX];
    logic [7:0]       win_next [PATTERN_MAX];
    logic [AW-1:0]    addr_reg, addr_next;
    logic [SW-1:0]    seen_reg, seen_next;
    logic             done_reg, done_next;

    logic             accept;
    logic             fire;
    logic             active;
    logic             empty_range;
    logic [AW-1:0]    base_addr;
    logic [LW-1:0]    len_use;
    logic [LW-1:0]    len_m1;
    logic [SW-1:0]    seen_inc;
    logic             cand_ready;
    logic [AW-1:0]    cand_start;
    logic             past_end;
    logic             last_cand;
    logic [127:0]     pattern;
    logic [PATTERN_MAX-1:0] hit;
    logic             match;
    logic [LW-1:0]    idx;
    logic [7:0]       pbyte;
    logic             emit;

    assign accept   = s_tvalid && s_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign active   = in_first_reg || !done_reg;

    // Hold the request until the result stage can take it
    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end
    end

    // Candidate start position and window for this byte
    always_comb
    begin
        base_addr   = in_first_reg ? cfg.start_address : addr_reg + AW'(1);
        empty_range = in_first_reg && (cfg.start_address >= cfg.end_address);

        if (cfg.pattern_length == '0)
        begin
            len_use = LW'(1);
        end
        else if (cfg.pattern_length > LW'(PATTERN_MAX))
        begin
            len_use = LW'(PATTERN_MAX);
        end
        else
        begin
            len_use = cfg.pattern_length;
        end
        len_m1 = len_use - LW'(1);

        if (in_first_reg)
        begin
            seen_inc = SW'(1);
        end
        else if (seen_reg == SW'(PATTERN_MAX))
        begin
            seen_inc = seen_reg;
        end
        else
        begin
            seen_inc = seen_reg + SW'(1);
        end

        win_next[0] = in_byte_reg;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            win_next[k] = win_reg[k-1];
        end

        cand_ready = LW'(seen_inc) >= len_use;
        cand_start = base_addr - AW'(len_m1);
        past_end   = cand_start >= cfg.end_address;
        last_cand  = (cand_start + AW'(1)) == cfg.end_address;
    end

    // Compare every pattern byte against its window slot, wildcard passes
    always_comb
    begin
        pattern = {cfg.pattern_high, cfg.pattern_low};
        idx     = '0;
        pbyte   = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            idx    = len_m1 - LW'(i);
            pbyte  = pattern[i*8 +: 8];
            hit[i] = (LW'(i) > len_m1) || (pbyte == wbps_pkg::WILDCARD)
                     || (pbyte == win_next[idx[IW-1:0]]);
        end
        match = &hit;
    end

    // Decide whether this byte ends the search
    always_comb
    begin
        emit = empty_range || (cand_ready && (past_end || match || last_cand));

        res.push          = fire && active && emit;
        res.found         = !empty_range && cand_ready && !past_end && match;
        res.match_address = res.found
                            ? cand_start + {{(AW-32){cfg.result_offset[31]}},
                                            cfg.result_offset}
                            : '0;

        addr_next = addr_reg;
        seen_next = seen_reg;
        done_next = done_reg;
        if (fire && active)
        begin
            addr_next = base_addr;
            seen_next = empty_range ? '0 : seen_inc;
            done_next = emit;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= data_byte;
            in_first_reg <= first;
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            seen_reg <= '0;
            done_reg <= 1'b1;
        end
        else
        begin
            addr_reg <= addr_next;
            seen_reg <= seen_next;
            done_reg <= done_next;
        end
    end

    // Window advances only on bytes that take part in a search
    always_ff @(posedge clk)
    begin
        if (fire && active)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // A result always closes the search
    a_push_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |=> done_reg)
        else $error("search still open after a result");

    // A closed search stays silent until a first byte
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && done_reg && !in_first_reg) |-> !res.push)
        else $error("result from an idle scan");

    // Byte count saturates at the window depth
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SW'(PATTERN_MAX))
        else $error("byte count beyond window depth");

endmodule

// ===== src/wbps_out.sv =====
`timescale 1ns / 1ps

module wbps_out
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  wbps_pkg::res_t               res,
    output logic                         out_free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic                         found,
    output logic [wbps_pkg::ADDR_W-1:0]  match_address
);

    logic                        vld_reg, vld_next;
    logic                        found_reg;
    logic [wbps_pkg::ADDR_W-1:0] addr_reg;

    assign out_free = !vld_reg || m_tready;

    // Load a new result, drop the old one once taken
    always_comb
    begin
        vld_next = vld_reg;
        if (res.push)
        begin
            vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            found_reg <= res.found;
            addr_reg  <= res.match_address;
        end
    end

    assign m_tvalid      = vld_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |-> (!vld_reg || m_tready))
        else $error("result overwritten before it was taken");

endmodule

// ===== src/wildcard_byte_pattern_scan.sv =====
`timescale 1ns / 1ps

// Wildcard byte pattern scan.
// Memory bytes enter on the s_ side in ascending address order; s_tuser
// marks the byte at start_address and restarts the search. Pattern bytes
// of 0xFF match any byte. At most one result per search leaves on the m_
// side: found=1 with the match start plus the signed offset, or found=0
// with address 0 once the last start below end_address has failed.
// Bytes arriving after a result are dropped until the next first byte.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, the block does not enforce it. Throughput:
// one byte per cycle while the output register is free; the input and
// result registers bound the only logic stage, which compares all window
// alignments in parallel, and the output register drives m_tvalid.
// Reset: no search active, registers at their defaults (length 1).
// Stall: while m_tready is low, one result waits in the output register
// and one more byte waits in the input register; s_tready then drops.

module wildcard_byte_pattern_scan
#(
    parameter int PATTERN_MAX = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    // byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] first
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wbps_pkg::ADDR_W-1:0]       m_tdata,   // [63:0] match_address
    output logic                              m_tuser    // [0] found
);

    wbps_pkg::cfg_t cfg;
    wbps_pkg::res_t res;
    logic           out_free;

    wbps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbps_scan
    #(
        .PATTERN_MAX (PATTERN_MAX)
    )
    u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .data_byte (s_tdata),
        .first     (s_tuser),
        .out_free  (out_free),
        .res       (res)
    );

    wbps_out u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .out_free      (out_free),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .found         (m_tuser),
        .match_address (m_tdata)
    );

endmodule

// ===== test/wildcard_byte_pattern_scan_test.sv =====
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_test;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 10;
    localparam int PAT_MAX       = 16;
    localparam int PHASES        = 12;
    localparam int PHASE_BYTES   = 98;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 5000;
    localparam int REPORT_MAX    = 10;

    // One byte request: data_byte plus the first flag
    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       first;
    } byte_req_t;

    // One scan result as it leaves the block
    typedef struct packed
    {
        logic                        found;
        logic [wbps_pkg::ADDR_W-1:0] match_address;
    } scan_hit_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata   = '0;     // [7:0] data_byte
    logic                             s_tuser   = 1'b0;   // [0] first
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [wbps_pkg::ADDR_W-1:0]      m_tdata;            // [63:0] match_address
    logic                             m_tuser;            // [0] found

    byte_req_t   byte_feed[$];
    scan_hit_t   expected_hits[$];

    int          errors        = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned hold_left     = 0;
    bit          hold_request  = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Register copies used for prediction
    logic [63:0]                 pat_low     = '0;
    logic [63:0]                 pat_high    = '0;
    logic [wbps_pkg::LEN_W-1:0]  pat_len     = 5'd1;
    logic [31:0]                 res_offset  = '0;
    logic [wbps_pkg::ADDR_W-1:0] range_start = '0;
    logic [wbps_pkg::ADDR_W-1:0] range_end   = '0;

    // Search state used for prediction
    logic [7:0]                  scan_window [PAT_MAX];
    logic [wbps_pkg::ADDR_W-1:0] scan_addr   = '0;
    int unsigned                 scan_count  = 0;
    bit                          scan_idle   = 1'b1;

    wildcard_byte_pattern_scan dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Clamp the programmed length to 1..PAT_MAX
    function automatic int unsigned used_len();
        int unsigned n;
        n = int'(pat_len);
        if (n == 0)
            n = 1;
        if (n > PAT_MAX)
            n = PAT_MAX;
        return n;
    endfunction

    function automatic logic [7:0] pattern_at(input int unsigned i);
        return (i < 8) ? pat_low[i * 8 +: 8] : pat_high[(i - 8) * 8 +: 8];
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= REPORT_MAX)
            $display("[%0t] %s", $time, msg);
    endfunction

    // Queue a result and stop the search until the next first byte
    function automatic void close_search(input logic found,
                                         input logic [wbps_pkg::ADDR_W-1:0] addr);
        expected_hits.push_back(scan_hit_t'{found, addr});
        scan_idle = 1'b1;
    endfunction

    // Advance the search by one accepted byte
    function automatic void predict_scan(input logic [7:0] b, input logic first);
        int unsigned                 n;
        int unsigned                 i;
        logic [wbps_pkg::ADDR_W-1:0] cand;
        logic [7:0]                  p;
        logic                        hit;
        if (first)
        begin
            for (i = 0; i < PAT_MAX; i++)
                scan_window[i] = '0;
            scan_count = 0;
            scan_addr  = range_start;
            scan_idle  = 1'b0;
            if (range_start >= range_end)
            begin
                close_search(1'b0, '0);
                return;
            end
        end
        else
        begin
            if (scan_idle)
                return;
            scan_addr = scan_addr + 64'd1;
        end

        for (i = PAT_MAX - 1; i > 0; i--)
            scan_window[i] = scan_window[i - 1];
        scan_window[0] = b;
        if (scan_count < PAT_MAX)
            scan_count++;

        n = used_len();
        if (scan_count < n)
            return;

        // Test the one start whose span ends at this byte
        cand = scan_addr - 64'(n - 1);
        if (cand >= range_end)
        begin
            close_search(1'b0, '0);
            return;
        end
        hit = 1'b1;
        for (i = 0; i < n; i++)
        begin
            p = pattern_at(i);
            if (p != wbps_pkg::WILDCARD && p != scan_window[n - 1 - i])
                hit = 1'b0;
        end
        if (hit)
            close_search(1'b1, cand + {{32{res_offset[31]}}, res_offset});
        else if (cand == range_end - 64'd1)
            close_search(1'b0, '0);
    endfunction

    // Driver: offer queued byte requests, predict each one accepted
    always @(posedge clk)
    begin
        byte_req_t req;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_scan(s_tdata, s_tuser);
            if (!s_tvalid || s_tready)
            begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req = byte_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.data_byte;
                    s_tuser  <= req.first;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation, drive ready
    always @(posedge clk)
    begin
        scan_hit_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_hits.size() == 0)
                begin
                    note_error($sformatf("unexpected result: found=%0b addr=%h",
                                         m_tuser, m_tdata));
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (m_tuser !== want.found)
                        note_error($sformatf("found: expected %0b, got %0b",
                                             want.found, m_tuser));
                    if (m_tdata !== want.match_address)
                        note_error($sformatf("match_address: expected %h, got %h",
                                             want.match_address, m_tdata));
                end
            end

            // Hold off for a long stretch once asked, else stall at random
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [wbps_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            wbps_pkg::CFG_PATTERN_LOW:  pat_low     = val;
            wbps_pkg::CFG_PATTERN_HIGH: pat_high    = val;
            wbps_pkg::CFG_PATTERN_LEN:  pat_len     = val[wbps_pkg::LEN_W-1:0];
            wbps_pkg::CFG_OFFSET:       res_offset  = val[31:0];
            wbps_pkg::CFG_START_ADDR:   range_start = val;
            wbps_pkg::CFG_END_ADDR:     range_end   = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every result has come back
    task automatic settle();
        do
        begin
            while (byte_feed.size() != 0 || s_tvalid || expected_hits.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (byte_feed.size() != 0 || s_tvalid || expected_hits.size() != 0);
    endtask

    // Queue one search: a first byte and total-1 more, optionally with
    // the pattern planted at a random position (wildcards get random bytes)
    function automatic void push_search(input int unsigned total, input bit plant);
        int unsigned n;
        int unsigned at;
        int unsigned k;
        logic [7:0]  b;
        n  = used_len();
        at = (plant && total >= n) ? $urandom_range(total - n) : total;
        for (k = 0; k < total; k++)
        begin
            b = 8'($urandom_range(255));
            if (k >= at && k < at + n && pattern_at(k - at) != wbps_pkg::WILDCARD)
                b = pattern_at(k - at);
            byte_feed.push_back(byte_req_t'{b, k == 0});
        end
    endfunction

    // Program every register with a fresh setting, extremes now and then
    task automatic random_config();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] addr;
        int unsigned k;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        for (k = 0; k < 8; k++)
        begin
            if ($urandom_range(3) == 0)
                lo[k * 8 +: 8] = wbps_pkg::WILDCARD;
            if ($urandom_range(3) == 0)
                hi[k * 8 +: 8] = wbps_pkg::WILDCARD;
        end
        write_reg(wbps_pkg::CFG_PATTERN_LOW, lo);
        write_reg(wbps_pkg::CFG_PATTERN_HIGH, hi);

        case ($urandom_range(9))
            0:       write_reg(wbps_pkg::CFG_PATTERN_LEN, 64'd0);
            1:       write_reg(wbps_pkg::CFG_PATTERN_LEN, 64'd16);
            2:       write_reg(wbps_pkg::CFG_PATTERN_LEN, 64'($urandom_range(31, 17)));
            default: write_reg(wbps_pkg::CFG_PATTERN_LEN, 64'($urandom_range(6, 1)));
        endcase

        case ($urandom_range(5))
            0:       write_reg(wbps_pkg::CFG_OFFSET, 64'h0000_0000_8000_0000);
            1:       write_reg(wbps_pkg::CFG_OFFSET, 64'h0000_0000_7FFF_FFFF);
            2:       write_reg(wbps_pkg::CFG_OFFSET, 64'd0);
            default: write_reg(wbps_pkg::CFG_OFFSET, {$urandom, $urandom});
        endcase

        case ($urandom_range(3))
            0:       addr = '0;
            1:       addr = '1 - 64'($urandom_range(20));
            default: addr = {$urandom, $urandom};
        endcase
        write_reg(wbps_pkg::CFG_START_ADDR, addr);

        // Mostly short ranges so searches end often; some empty or wrapped
        case ($urandom_range(9))
            0:       write_reg(wbps_pkg::CFG_END_ADDR, '1);
            1:       write_reg(wbps_pkg::CFG_END_ADDR, addr - 64'($urandom_range(3)));
            default: write_reg(wbps_pkg::CFG_END_ADDR, addr + 64'($urandom_range(40, 1)));
        endcase
    endtask

    // Fill the request queue for one phase of random traffic
    function automatic void fill_phase(input int unsigned count);
        logic [63:0] span;
        int unsigned limit;
        int unsigned k;
        span  = (range_end > range_start) ? range_end - range_start : 64'd0;
        limit = (span < 48) ? 32'(span) + used_len() + 2 : 64;
        // bytes without first: carry on an open search under the new registers
        for (k = 0; k < 2; k++)
            byte_feed.push_back(byte_req_t'{8'($urandom_range(255)), 1'b0});
        while (byte_feed.size() < count)
        begin
            case ($urandom_range(9))
                0:
                begin
                    for (k = $urandom_range(3, 1); k > 0; k--)
                        byte_feed.push_back(byte_req_t'{8'($urandom_range(255)), 1'b0});
                end
                1:       push_search($urandom_range(3, 1), 1'b0);
                default: push_search($urandom_range(limit, 1), $urandom_range(3) != 0);
            endcase
        end
    endfunction

    initial
    begin
        int unsigned ph;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 33;
        recv_idle_pct = 80;

        // Drop bytes while no search is open, then an empty range at reset values
        byte_feed.push_back(byte_req_t'{8'h00, 1'b0});
        byte_feed.push_back(byte_req_t'{8'hFF, 1'b0});
        byte_feed.push_back(byte_req_t'{8'h5A, 1'b1});
        settle();

        // Three-byte pattern with a wildcard, range at the top of memory,
        // most negative offset; the address wraps during the search
        write_reg(wbps_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0000_FFAB);
        write_reg(wbps_pkg::CFG_PATTERN_LEN, 64'd3);
        write_reg(wbps_pkg::CFG_OFFSET, 64'h0000_0000_8000_0000);
        write_reg(wbps_pkg::CFG_START_ADDR, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(wbps_pkg::CFG_END_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
        byte_feed.push_back(byte_req_t'{8'hAB, 1'b1});
        byte_feed.push_back(byte_req_t'{8'h55, 1'b0});
        byte_feed.push_back(byte_req_t'{8'h00, 1'b0});
        byte_feed.push_back(byte_req_t'{8'h12, 1'b0});
        byte_feed.push_back(byte_req_t'{8'hFF, 1'b1});
        byte_feed.push_back(byte_req_t'{8'h00, 1'b0});
        byte_feed.push_back(byte_req_t'{8'h00, 1'b0});
        settle();

        // Length zero acts as one; single wildcard, largest positive offset
        write_reg(wbps_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
        write_reg(wbps_pkg::CFG_PATTERN_LEN, 64'd0);
        write_reg(wbps_pkg::CFG_OFFSET, 64'h0000_0000_7FFF_FFFF);
        write_reg(wbps_pkg::CFG_START_ADDR, 64'd0);
        write_reg(wbps_pkg::CFG_END_ADDR, '1);
        byte_feed.push_back(byte_req_t'{8'h00, 1'b1});
        settle();

        // Length above the maximum acts as sixteen; window fills first
        write_reg(wbps_pkg::CFG_PATTERN_LOW, '1);
        write_reg(wbps_pkg::CFG_PATTERN_HIGH, 64'h00FF_FFFF_FFFF_FFFF);
        write_reg(wbps_pkg::CFG_PATTERN_LEN, 64'd31);
        write_reg(wbps_pkg::CFG_START_ADDR, 64'd100);
        write_reg(wbps_pkg::CFG_END_ADDR, 64'd200);
        push_search(16, 1'b1);
        settle();

        // Random phases: sender-light idling, receiver-light idling, then none
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES / 3)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 33;
            end
            if (ph == 2 * PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_config();
            fill_phase(PHASE_BYTES);
            if (ph == 2 * PHASES / 3)
                hold_request = 1'b1;
            settle();
        end

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && expected_hits.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
